// ===== hdl/dtbp_pkg.sv =====
// types and constants shared by the dual token bucket policer
package dtbp_pkg;

  // register map, word index taken from paddr[3:2]
  localparam int unsigned RegAddrW = 2;
  localparam logic [RegAddrW-1:0] REG_BYTE_RATE    = 2'd0;
  localparam logic [RegAddrW-1:0] REG_BYTE_BURST   = 2'd1;
  localparam logic [RegAddrW-1:0] REG_PACKET_RATE  = 2'd2;
  localparam logic [RegAddrW-1:0] REG_PACKET_BURST = 2'd3;

  // register reset values
  localparam logic [31:0] BYTE_RATE_RST    = 32'(10 * 1024);
  localparam logic [31:0] BYTE_BURST_RST   = 32'(20 * 1024);
  localparam logic [31:0] PACKET_RATE_RST  = 32'd10;
  localparam logic [31:0] PACKET_BURST_RST = 32'd50;

  // stream widths
  localparam int unsigned BytesW   = 16;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 8;

  typedef enum logic [1:0] {
    VERDICT_PASS      = 2'd0,
    VERDICT_OVER_BYTE = 2'd1,
    VERDICT_OVER_PKT  = 2'd2
  } verdict_e;

  // outcome of policing one cost against one bucket
  typedef struct packed {
    logic [31:0] level;
    logic [31:0] last;
    logic        refill;
    logic        pass;
  } bucket_t;

endpackage

// ===== hdl/dual_token_bucket_policer_core.sv =====
// dual token bucket policer: byte then packet bucket, one packet per cycle unless stalled
// path: an accepted input waits in the input register, its verdict in the result register
// throughput: one packet per cycle unless the output stalls, set by the bucket update loop
//   (one 32x32 multiply, a wide add, clamp to burst and cost subtract per bucket)
// reset: asynchronous, clears both bucket levels and last-refill times, empties
//   the input and result registers, and loads the rate and burst registers with defaults
module dual_token_bucket_policer_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // input packet stream
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [47:0]              s_axis_tdata,   // [15:0] packet_bytes, [47:16] now_ms
  // verdict stream
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [7:0]               m_axis_tdata,   // [1:0] verdict, [7:2] zero
  // configuration port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [3:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import dtbp_pkg::*;

  // police one cost against one bucket: refill only when the cost exceeds the level
  function automatic bucket_t bucket_take(
    input logic [31:0] level,
    input logic [31:0] last,
    input logic [31:0] rate,
    input logic [31:0] burst,
    input logic [31:0] cost,
    input logic [31:0] now
  );
    bucket_t     res;
    logic [31:0] elapsed;
    logic [63:0] prod;
    logic [64:0] sum;
    logic [31:0] lvl;
    elapsed = now - last;                      // wraps modulo 2^32
    prod    = 64'(rate) * 64'(elapsed);
    sum     = 65'(level) + 65'(prod);          // wide, cannot wrap
    res.refill = (cost > level);
    if (res.refill) begin
      lvl      = (sum > 65'(burst)) ? burst : sum[31:0];
      res.last = now;
    end else begin
      lvl      = level;
      res.last = last;
    end
    res.pass  = (cost <= lvl);
    res.level = res.pass ? (lvl - cost) : lvl;
    return res;
  endfunction

  // configuration registers
  logic [31:0] byte_rate_q, byte_burst_q, packet_rate_q, packet_burst_q;
  logic        cfg_wr;

  // bucket state
  logic [31:0] byte_tokens_q, byte_last_q, pkt_tokens_q, pkt_last_q;

  // input register
  logic              in_valid_q;
  logic [BytesW-1:0] in_bytes_q;
  logic [TimeW-1:0]  in_now_q;

  // result register
  logic     out_valid_q;
  verdict_e verdict_q;

  // handshake control
  logic    out_free, fire, in_take;
  bucket_t byte_res, pkt_res;
  verdict_e verdict_d;

  // the result register empties when the sink takes it, so the input register
  // drains into it in the same cycle
  assign out_free      = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // apb: no wait states, word index from paddr[3:2]
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[3:2])
      REG_BYTE_RATE:    prdata = byte_rate_q;
      REG_BYTE_BURST:   prdata = byte_burst_q;
      REG_PACKET_RATE:  prdata = packet_rate_q;
      REG_PACKET_BURST: prdata = packet_burst_q;
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_rate_q    <= BYTE_RATE_RST;
      byte_burst_q   <= BYTE_BURST_RST;
      packet_rate_q  <= PACKET_RATE_RST;
      packet_burst_q <= PACKET_BURST_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_BYTE_RATE:    byte_rate_q    <= pwdata;
        REG_BYTE_BURST:   byte_burst_q   <= pwdata;
        REG_PACKET_RATE:  packet_rate_q  <= pwdata;
        REG_PACKET_BURST: packet_burst_q <= pwdata;
        default: ;
      endcase
    end
  end

  // both buckets are evaluated in parallel; the packet bucket only commits
  // when the byte bucket passes
  always_comb begin
    byte_res = bucket_take(byte_tokens_q, byte_last_q, byte_rate_q, byte_burst_q,
                           32'(in_bytes_q), in_now_q);
    pkt_res  = bucket_take(pkt_tokens_q, pkt_last_q, packet_rate_q, packet_burst_q,
                           32'd1, in_now_q);
    if (!byte_res.pass) begin
      verdict_d = VERDICT_OVER_BYTE;
    end else if (!pkt_res.pass) begin
      verdict_d = VERDICT_OVER_PKT;
    end else begin
      verdict_d = VERDICT_PASS;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_bytes_q <= s_axis_tdata[15:0];
      in_now_q   <= s_axis_tdata[47:16];
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      verdict_q <= verdict_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      byte_tokens_q <= '0;
      byte_last_q   <= '0;
      pkt_tokens_q  <= '0;
      pkt_last_q    <= '0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (fire) begin
        byte_tokens_q <= byte_res.level;
        byte_last_q   <= byte_res.last;
        if (byte_res.pass) begin
          pkt_tokens_q <= pkt_res.level;
          pkt_last_q   <= pkt_res.last;
        end
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, verdict_q};

  // every processed packet yields a verdict in the next cycle
  a_fire_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> m_axis_tvalid)
    else $error("processed packet produced no verdict");

  // bucket state only moves when a packet is processed
  a_state_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(byte_tokens_q) && $stable(pkt_tokens_q) &&
              $stable(byte_last_q) && $stable(pkt_last_q))
    else $error("bucket state changed without a packet");

  // a byte-limit failure leaves the packet bucket untouched
  a_byte_fail_pkt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !byte_res.pass |=> $stable(pkt_tokens_q) && $stable(pkt_last_q))
    else $error("packet bucket changed on byte failure");

  // a byte refill stamps the packet time
  a_byte_stamp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && byte_res.refill |=> byte_last_q == $past(in_now_q))
    else $error("byte refill time not updated");

endmodule

// ===== tb/tb_dual_token_bucket_policer_core.sv =====
// self-checking testbench for the dual token bucket policer core
`timescale 1ns / 100ps

module tb_dual_token_bucket_policer_core;
  import dtbp_pkg::*;

  // predicts each verdict from its own copy of both buckets and holds the verdicts still owed
  class verdict_scoreboard;
    logic [31:0] byte_rate, byte_burst, pkt_rate, pkt_burst;
    logic [31:0] byte_level, byte_stamp, pkt_level, pkt_stamp;
    verdict_e    verdict_q[$];
    int unsigned errors;
    int unsigned n_pass, n_over_byte, n_over_pkt;

    function new();
      byte_rate   = BYTE_RATE_RST;
      byte_burst  = BYTE_BURST_RST;
      pkt_rate    = PACKET_RATE_RST;
      pkt_burst   = PACKET_BURST_RST;
      byte_level  = '0;
      byte_stamp  = '0;
      pkt_level   = '0;
      pkt_stamp   = '0;
      errors      = 0;
      n_pass      = 0;
      n_over_byte = 0;
      n_over_pkt  = 0;
    endfunction

    function void set_reg(logic [RegAddrW-1:0] idx, logic [31:0] value);
      case (idx)
        REG_BYTE_RATE:    byte_rate  = value;
        REG_BYTE_BURST:   byte_burst = value;
        REG_PACKET_RATE:  pkt_rate   = value;
        REG_PACKET_BURST: pkt_burst  = value;
        default: ;
      endcase
    endfunction

    function logic [31:0] reg_value(logic [RegAddrW-1:0] idx);
      case (idx)
        REG_BYTE_RATE:    return byte_rate;
        REG_BYTE_BURST:   return byte_burst;
        REG_PACKET_RATE:  return pkt_rate;
        default:          return pkt_burst;
      endcase
    endfunction

    // refill only when the cost is above the level, sum formed wide and clamped at the burst
    function bit take_tokens(inout logic [31:0] level, inout logic [31:0] stamp,
                             input logic [31:0] rate, input logic [31:0] burst,
                             input logic [31:0] cost, input logic [31:0] now);
      logic [31:0] elapsed;
      logic [63:0] total;
      if (cost > level) begin
        elapsed = now - stamp;
        total   = {32'd0, level} + {32'd0, rate} * {32'd0, elapsed};
        if (total > {32'd0, burst}) total = {32'd0, burst};
        level = total[31:0];
        stamp = now;
      end
      if (cost <= level) begin
        level = level - cost;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_packet(logic [BytesW-1:0] bytes, logic [TimeW-1:0] now);
      verdict_e v;
      // packet bucket is left alone when the byte bucket fails
      if (!take_tokens(byte_level, byte_stamp, byte_rate, byte_burst, {16'd0, bytes}, now))
        v = VERDICT_OVER_BYTE;
      else if (!take_tokens(pkt_level, pkt_stamp, pkt_rate, pkt_burst, 32'd1, now))
        v = VERDICT_OVER_PKT;
      else
        v = VERDICT_PASS;
      verdict_q.push_back(v);
    endfunction

    function void check_verdict(logic [OutDataW-1:0] data);
      verdict_e expected;
      if (verdict_q.size() == 0) begin
        $display("%0t: verdict %0d with none outstanding", $time, data);
        errors++;
        return;
      end
      expected = verdict_q.pop_front();
      if (data !== {6'd0, expected}) begin
        $display("%0t: verdict mismatch, expected %0d (%s) actual %0d",
                 $time, expected, expected.name(), data);
        errors++;
      end else begin
        case (expected)
          VERDICT_PASS:      n_pass++;
          VERDICT_OVER_BYTE: n_over_byte++;
          default:           n_over_pkt++;
        endcase
      end
    endfunction

    function int unsigned pending();
      return verdict_q.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;   // [15:0] packet_bytes, [47:16] now_ms
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;   // [1:0] verdict, [7:2] zero
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [3:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  verdict_scoreboard sb;
  bit                quiet;        // no gaps or stalls while set
  int unsigned       stall_left;
  int unsigned       settings;

  dual_token_bucket_policer_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side: check every verdict transaction, stall at random
  initial begin
    m_axis_tready = 1'b0;
    stall_left    = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_verdict(m_axis_tdata);
      if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < 25) begin
        stall_left = pick_gap();
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_packet(input logic [BytesW-1:0] bytes, input logic [TimeW-1:0] now);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {now, bytes};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_packet(bytes, now);
  endtask

  // wait for every verdict, then let the two-stage pipe drain
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic write_en, input logic [RegAddrW-1:0] idx,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write_en;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_reg(input logic [RegAddrW-1:0] idx);
    logic [31:0] rdata;
    apb_access(1'b0, idx, 32'd0, rdata);
    if (rdata !== sb.reg_value(idx)) begin
      $display("%0t: register %0d read back, expected %h actual %h",
               $time, idx, sb.reg_value(idx), rdata);
      sb.errors++;
    end
  endtask

  task automatic write_reg(input logic [RegAddrW-1:0] idx, input logic [31:0] value);
    logic [31:0] unused;
    apb_access(1'b1, idx, value, unused);
    sb.set_reg(idx, value);
    check_reg(idx);
  endtask

  task automatic configure(input logic [31:0] b_rate, input logic [31:0] b_burst,
                           input logic [31:0] p_rate, input logic [31:0] p_burst);
    write_reg(REG_BYTE_RATE, b_rate);
    write_reg(REG_BYTE_BURST, b_burst);
    write_reg(REG_PACKET_RATE, p_rate);
    write_reg(REG_PACKET_BURST, p_burst);
    settings++;
  endtask

  // register value: mostly a moderate figure, sometimes zero, all ones or anything
  function automatic logic [31:0] pick_setting(int unsigned typical_max);
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom();
      default: return $urandom_range(0, typical_max);
    endcase
  endfunction

  // mostly a clock creeping forward with moderate packets, some jumbo lengths and time jumps
  task automatic run_traffic(input int unsigned count, inout logic [31:0] clock_ms);
    int unsigned r;
    logic [BytesW-1:0] bytes;
    for (int unsigned n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        clock_ms = clock_ms + $urandom_range(0, 2);
        bytes    = (r < 5) ? 16'd0 : 16'($urandom_range(0, 2500));
      end else if (r < 90) begin
        clock_ms = clock_ms + $urandom_range(0, 3);
        bytes    = 16'($urandom());
      end else begin
        // jump anywhere, backwards included
        clock_ms = $urandom();
        bytes    = 16'($urandom());
      end
      send_packet(bytes, clock_ms);
    end
  endtask

  initial begin
    logic [31:0] clock_ms;
    sb            = new();
    quiet         = 1'b0;
    settings      = 0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values of the registers
    check_reg(REG_BYTE_RATE);
    check_reg(REG_BYTE_BURST);
    check_reg(REG_PACKET_RATE);
    check_reg(REG_PACKET_BURST);

    // empty buckets after reset, zero length still charged to the packet bucket
    send_packet(16'd0, 32'd0);
    send_packet(16'd100, 32'd1);
    send_packet(16'hFFFF, 32'd2);
    send_packet(16'd0, 32'd2);
    send_packet(16'd1, 32'hFFFF_FFFF);
    // time wraps from all ones to zero, then a cost exactly at the burst
    send_packet(16'hFFFF, 32'd0);
    send_packet(16'd20480, 32'd0);
    send_packet(16'd1, 32'd0);
    send_packet(16'h5555, 32'hAAAA_AAAA);
    send_packet(16'hAAAA, 32'h5555_5555);
    settle();

    // fill the byte bucket high, then lower the burst below its level
    configure(32'd60000, 32'd60000, PACKET_RATE_RST, PACKET_BURST_RST);
    send_packet(16'hFFFF, 32'h5555_5556);
    settle();
    configure(32'd1, 32'd1000, PACKET_RATE_RST, PACKET_BURST_RST);
    send_packet(16'd100, 32'h5555_5557);
    send_packet(16'hFFFF, 32'h5555_5558);
    send_packet(16'd1000, 32'h5555_5558);
    settle();

    // all-ones rates and bursts, refill product near the top of 64 bits
    configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_packet(16'hFFFF, 32'h5555_5559);
    send_packet(16'hFFFF, 32'hD555_5555);
    send_packet(16'hFFFF, 32'hD555_5555);
    send_packet(16'd0, 32'hD555_5556);
    settle();

    // zero everything, levels left above the new bursts
    configure(32'd0, 32'd0, 32'd0, 32'd0);
    send_packet(16'd0, 32'd7);
    send_packet(16'd1, 32'd12);
    send_packet(16'hFFFF, 32'd112);
    settle();

    clock_ms = $urandom();
    for (int unsigned phase = 0; phase < 8; phase++) begin
      quiet = ($urandom_range(0, 3) == 0);
      configure(pick_setting(4000), pick_setting(30000), pick_setting(3), pick_setting(10));
      run_traffic(100, clock_ms);
      settle();
    end
    quiet = 1'b0;

    $display("covered %0d register settings; verdicts seen: %0d conforming,",
             settings, sb.n_pass);
    $display("  %0d over byte limit, %0d over packet limit, %0d errors",
             sb.n_over_byte, sb.n_over_pkt, sb.errors);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
